// ----- src/ipid_pkg.sv -----
package ipid_pkg;

  localparam int FrameBitsDefault = 32;

  localparam int IntervalWidth = 16;
  localparam int CodeWidth     = 8;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  localparam logic [IntervalWidth-1:0] LeaderMinReset = 16'd17400;
  localparam logic [IntervalWidth-1:0] LeaderMaxReset = 16'd30000;
  localparam logic [IntervalWidth-1:0] ZeroMinReset   = 16'd1520;
  localparam logic [IntervalWidth-1:0] BitSplitReset  = 16'd3200;
  localparam logic [IntervalWidth-1:0] OneMaxReset    = 16'd6400;
  localparam logic [CodeWidth-1:0]     UserCodeReset  = 8'd0;
  localparam logic [CodeWidth-1:0]     KeyCodeReset   = 8'd0;

  // New bits land in the top of the byte, which shifts right.
  localparam logic [CodeWidth-1:0] BitInMask = 8'h80;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_LEADER_MIN = 3'd0,
    CFG_LEADER_MAX = 3'd1,
    CFG_ZERO_MIN   = 3'd2,
    CFG_BIT_SPLIT  = 3'd3,
    CFG_ONE_MAX    = 3'd4,
    CFG_USER_CODE  = 3'd5,
    CFG_KEY_CODE   = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [IntervalWidth-1:0] leader_min;
    logic [IntervalWidth-1:0] leader_max;
    logic [IntervalWidth-1:0] zero_min;
    logic [IntervalWidth-1:0] bit_split;
    logic [IntervalWidth-1:0] one_max;
    logic [CodeWidth-1:0]     user_code;
    logic [CodeWidth-1:0]     key_code;
  } cfg_t;

  typedef struct packed {
    logic                 leader_seen;
    logic                 frame_done;
    logic                 frame_ok;
    logic [CodeWidth-1:0] key_value;
    logic [CodeWidth-1:0] leader_total;
  } result_t;

  function automatic logic in_band(input logic [IntervalWidth-1:0] v,
                                   input logic [IntervalWidth-1:0] lo,
                                   input logic [IntervalWidth-1:0] hi);
    in_band = (v > lo) && (v < hi);
  endfunction

endpackage

// ----- src/ipid_cfg_regs.sv -----
module ipid_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ipid_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [ipid_pkg::CfgDataWidth-1:0]   cfg_wdata,
  output ipid_pkg::cfg_t                      cfg
);
  import ipid_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LEADER_MIN: cfg_nxt.leader_min = cfg_wdata;
        CFG_LEADER_MAX: cfg_nxt.leader_max = cfg_wdata;
        CFG_ZERO_MIN:   cfg_nxt.zero_min   = cfg_wdata;
        CFG_BIT_SPLIT:  cfg_nxt.bit_split  = cfg_wdata;
        CFG_ONE_MAX:    cfg_nxt.one_max    = cfg_wdata;
        CFG_USER_CODE:  cfg_nxt.user_code  = cfg_wdata[CodeWidth-1:0];
        CFG_KEY_CODE:   cfg_nxt.key_code   = cfg_wdata[CodeWidth-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leader_min <= LeaderMinReset;
      cfg_r.leader_max <= LeaderMaxReset;
      cfg_r.zero_min   <= ZeroMinReset;
      cfg_r.bit_split  <= BitSplitReset;
      cfg_r.one_max    <= OneMaxReset;
      cfg_r.user_code  <= UserCodeReset;
      cfg_r.key_code   <= KeyCodeReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/ipid_decode.sv -----
module ipid_decode #(
  parameter int FRAME_BITS = ipid_pkg::FrameBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [ipid_pkg::IntervalWidth-1:0]  interval,
  input  ipid_pkg::cfg_t                      cfg,
  output ipid_pkg::result_t                   result
);
  import ipid_pkg::*;

  localparam int CountWidth = $clog2(FRAME_BITS);
  localparam logic [CountWidth-1:0] LastBit = CountWidth'(FRAME_BITS - 1);

  logic                  armed_r, armed_nxt;
  logic [CountWidth-1:0] bit_count_r, bit_count_nxt;
  logic [CodeWidth-1:0]  bytes_r [4];
  logic [CodeWidth-1:0]  bytes_nxt [4];
  logic                  valid_flag_r, valid_flag_nxt;
  logic [CodeWidth-1:0]  key_hold_r, key_hold_nxt;
  logic [CodeWidth-1:0]  leader_cnt_r, leader_cnt_nxt;

  logic                  is_leader, is_one, is_zero, done;
  logic [6:0]            count_wide;
  logic [1:0]            byte_idx;
  logic [CodeWidth-1:0]  shifted;
  logic                  frame_good;

  always_comb begin
    is_leader  = in_band(interval, cfg.leader_min, cfg.leader_max);
    is_one     = in_band(interval, cfg.bit_split, cfg.one_max);
    is_zero    = in_band(interval, cfg.zero_min, cfg.bit_split);
    count_wide = 7'(bit_count_r);
    // Bits past the fourth byte wrap back into the first one.
    byte_idx   = count_wide[4:3];
    shifted    = (bytes_r[byte_idx] >> 1) | (is_one ? BitInMask : '0);

    armed_nxt      = armed_r;
    bit_count_nxt  = bit_count_r;
    bytes_nxt      = bytes_r;
    valid_flag_nxt = valid_flag_r;
    key_hold_nxt   = key_hold_r;
    leader_cnt_nxt = leader_cnt_r;
    done           = 1'b0;

    if (is_leader) begin
      armed_nxt      = 1'b1;
      bit_count_nxt  = '0;
      leader_cnt_nxt = leader_cnt_r + 1'b1;
    end else if (armed_r) begin
      if (is_one || is_zero) begin
        bytes_nxt[byte_idx] = shifted;
        if (bit_count_r == LastBit) begin
          armed_nxt     = 1'b0;
          bit_count_nxt = '0;
          done          = 1'b1;
        end else begin
          bit_count_nxt = bit_count_r + 1'b1;
        end
      end else begin
        armed_nxt     = 1'b0;
        bit_count_nxt = '0;
      end
    end

    // The check sees the bytes including the bit that completes the frame.
    frame_good = (bytes_nxt[0] == ~bytes_nxt[1]) && (bytes_nxt[0] == cfg.user_code) &&
                 (bytes_nxt[2] == ~bytes_nxt[3]) && (bytes_nxt[2] == cfg.key_code);
    if (done) begin
      valid_flag_nxt = frame_good;
      key_hold_nxt   = frame_good ? bytes_nxt[2] : '0;
    end

    result.leader_seen  = is_leader;
    result.frame_done   = done;
    result.frame_ok     = valid_flag_nxt;
    result.key_value    = key_hold_nxt;
    result.leader_total = leader_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      bit_count_r  <= '0;
      bytes_r      <= '{default: '0};
      valid_flag_r <= 1'b0;
      key_hold_r   <= '0;
      leader_cnt_r <= '0;
    end else if (step) begin
      armed_r      <= armed_nxt;
      bit_count_r  <= bit_count_nxt;
      bytes_r      <= bytes_nxt;
      valid_flag_r <= valid_flag_nxt;
      key_hold_r   <= key_hold_nxt;
      leader_cnt_r <= leader_cnt_nxt;
    end
  end

endmodule

// ----- src/ir_pulse_interval_decoder.sv -----
// An accepted interval word goes through the input register, then the result
// register. Throughput: one interval word per cycle unless out_stall holds a
// full result register; the decoder state updates as the word moves from the
// input register into the result register.
// Reset (rst_n, synchronous, active low) clears the decoder state, the valid
// flags and loads the default band limits and codes.
module ir_pulse_interval_decoder #(
  parameter int FRAME_BITS = ipid_pkg::FrameBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ipid_pkg::IntervalWidth-1:0]  in_interval,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_leader_seen,
  output logic                                out_frame_done,
  output logic                                out_frame_ok,
  output logic [ipid_pkg::CodeWidth-1:0]      out_key_value,
  output logic [ipid_pkg::CodeWidth-1:0]      out_leader_total,
  input  logic                                cfg_we,
  input  logic [ipid_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [ipid_pkg::CfgDataWidth-1:0]   cfg_wdata
);
  import ipid_pkg::*;

  cfg_t                     cfg;
  result_t                  result;
  result_t                  out_r;
  logic                     s1_valid_r;
  logic [IntervalWidth-1:0] s1_interval_r;
  logic                     out_valid_r;
  logic                     advance;
  logic                     in_take;

  ipid_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The result register frees up when empty or when its word is taken.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  ipid_decode #(
    .FRAME_BITS (FRAME_BITS)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .interval (s1_interval_r),
    .cfg      (cfg),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_interval_r <= in_interval;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_leader_seen  = out_r.leader_seen;
  assign out_frame_done   = out_r.frame_done;
  assign out_frame_ok     = out_r.frame_ok;
  assign out_key_value    = out_r.key_value;
  assign out_leader_total = out_r.leader_total;

  a_not_both : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.leader_seen && out_r.frame_done))
    else $error("leader and frame completion reported for the same word");

  a_key_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.frame_ok) |-> (out_r.key_value == '0))
    else $error("key value held nonzero without a valid frame");

  a_stall_src : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline could move");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result word dropped");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import ipid_pkg::*;

  localparam int FrameBits = FrameBitsDefault;
  // No register answers at this index; a write there must change nothing.
  localparam logic [CfgIndexWidth-1:0] CfgUnusedIndex = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [IntervalWidth-1:0] in_interval;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_leader_seen;
  logic                     out_frame_done;
  logic                     out_frame_ok;
  logic [CodeWidth-1:0]     out_key_value;
  logic [CodeWidth-1:0]     out_leader_total;
  logic                     cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_wdata;

  ir_pulse_interval_decoder #(.FRAME_BITS(FrameBits)) uut (.*);

  // Decoder state as the testbench sees it.
  cfg_t                 band_cfg;
  logic                 armed;
  logic [6:0]           bit_count;
  logic [CodeWidth-1:0] frame_bytes [4];
  logic                 frame_ok_hold;
  logic [CodeWidth-1:0] key_hold;
  logic [CodeWidth-1:0] leader_count;

  result_t pending_results [$];
  result_t got;
  result_t want;
  int      error_count = 0;
  int      send_idle_pct;
  int      recv_idle_pct;
  logic    hold_on = 1'b0;

  always #5 clk = ~clk;

  function automatic void decode_interval(input logic [IntervalWidth-1:0] iv);
    result_t    r;
    logic [1:0] sel;
    logic       take;
    r = '0;
    if (iv > band_cfg.leader_min && iv < band_cfg.leader_max) begin
      r.leader_seen = 1'b1;
      bit_count = '0;
      armed = 1'b1;
      leader_count = leader_count + 8'd1;
    end else if (armed) begin
      sel = bit_count[4:3];
      take = 1'b1;
      if (iv > band_cfg.bit_split && iv < band_cfg.one_max)
        frame_bytes[sel] = {1'b1, frame_bytes[sel][CodeWidth-1:1]};
      else if (iv > band_cfg.zero_min && iv < band_cfg.bit_split)
        frame_bytes[sel] = {1'b0, frame_bytes[sel][CodeWidth-1:1]};
      else
        take = 1'b0;
      if (!take) begin
        bit_count = '0;
        armed = 1'b0;
      end else if (bit_count + 1 >= FrameBits) begin
        bit_count = '0;
        armed = 1'b0;
        r.frame_done = 1'b1;
        frame_ok_hold = ((frame_bytes[0] ^ frame_bytes[1]) == 8'hFF) &&
                        (frame_bytes[0] == band_cfg.user_code) &&
                        ((frame_bytes[2] ^ frame_bytes[3]) == 8'hFF) &&
                        (frame_bytes[2] == band_cfg.key_code);
        key_hold = frame_ok_hold ? frame_bytes[2] : '0;
      end else begin
        bit_count = bit_count + 7'd1;
      end
    end
    r.frame_ok = frame_ok_hold;
    r.key_value = key_hold;
    r.leader_total = leader_count;
    pending_results.push_back(r);
  endfunction

  // Value strictly inside (lo, hi), with the edges picked now and then.
  function automatic logic [IntervalWidth-1:0] pick_in(input logic [IntervalWidth-1:0] lo,
                                                       input logic [IntervalWidth-1:0] hi);
    case ($urandom_range(9))
      0: return lo + 16'd1;
      1: return hi - 16'd1;
      default: return IntervalWidth'($urandom_range(hi - 1, lo + 1));
    endcase
  endfunction

  function automatic logic [IntervalWidth-1:0] fault_interval();
    case ($urandom_range(3))
      0: return band_cfg.bit_split;
      1: return band_cfg.one_max;
      2: return band_cfg.zero_min;
      default: return IntervalWidth'($urandom_range(65535));
    endcase
  endfunction

  always @(negedge clk)
    out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got = {out_leader_seen, out_frame_done, out_frame_ok, out_key_value, out_leader_total};
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %p", got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.leader_seen !== want.leader_seen) begin
          $error("leader_seen: expected %0d, got %0d", want.leader_seen, got.leader_seen);
          error_count++;
        end
        if (got.frame_done !== want.frame_done) begin
          $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
          error_count++;
        end
        if (got.frame_ok !== want.frame_ok) begin
          $error("frame_ok: expected %0d, got %0d", want.frame_ok, got.frame_ok);
          error_count++;
        end
        if (got.key_value !== want.key_value) begin
          $error("key_value: expected %0h, got %0h", want.key_value, got.key_value);
          error_count++;
        end
        if (got.leader_total !== want.leader_total) begin
          $error("leader_total: expected %0d, got %0d", want.leader_total, got.leader_total);
          error_count++;
        end
      end
    end
  end

  task automatic send_interval(input logic [IntervalWidth-1:0] iv);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_interval <= iv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_interval(iv);
  endtask

  // Lets every outstanding word come out, then lets the pipeline settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIndexWidth-1:0] idx,
                                input logic [CfgDataWidth-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_LEADER_MIN: band_cfg.leader_min = value;
      CFG_LEADER_MAX: band_cfg.leader_max = value;
      CFG_ZERO_MIN:   band_cfg.zero_min = value;
      CFG_BIT_SPLIT:  band_cfg.bit_split = value;
      CFG_ONE_MAX:    band_cfg.one_max = value;
      CFG_USER_CODE:  band_cfg.user_code = value[CodeWidth-1:0];
      CFG_KEY_CODE:   band_cfg.key_code = value[CodeWidth-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_bands(input logic [IntervalWidth-1:0] lmin, lmax, zmin, split, omax,
                           input logic [CodeWidth-1:0] user, key);
    drain();
    write_register(CFG_LEADER_MIN, lmin);
    write_register(CFG_LEADER_MAX, lmax);
    write_register(CFG_ZERO_MIN, zmin);
    write_register(CFG_BIT_SPLIT, split);
    write_register(CFG_ONE_MAX, omax);
    write_register(CFG_USER_CODE, CfgDataWidth'(user));
    write_register(CFG_KEY_CODE, CfgDataWidth'(key));
  endtask

  // Leader, then the 32-bit word LSB first. At cut_at a fault or a fresh
  // leader is slipped in ahead of that bit.
  task automatic send_frame(input logic [31:0] word, input int cut_at, input logic cut_by_leader);
    int i;
    send_interval(pick_in(band_cfg.leader_min, band_cfg.leader_max));
    for (i = 0; i < FrameBits; i++) begin
      if (i == cut_at)
        send_interval(cut_by_leader ? pick_in(band_cfg.leader_min, band_cfg.leader_max)
                                    : fault_interval());
      send_interval(word[i % 32] ? pick_in(band_cfg.bit_split, band_cfg.one_max)
                                 : pick_in(band_cfg.zero_min, band_cfg.bit_split));
    end
  endtask

  task automatic test_band_edges();
    send_interval(16'd0);
    send_interval(16'd65535);
    send_interval(16'd17400);
    send_interval(16'd17401);
    send_interval(16'd3200);   // exactly on the split: a fault
    send_interval(16'd1521);   // ignored while disarmed
    send_interval(16'd29999);
    send_interval(16'd3201);
    send_interval(16'd6399);
    send_interval(16'd1521);
    send_interval(16'd3199);
    send_interval(16'd17401);  // a leader restarts even in the middle of a frame
    send_interval(16'd6400);
    send_interval(16'd30000);
    send_interval(16'd17401);
    send_interval(16'd1520);
    send_interval(16'd17401);
    send_interval(16'd0);
    send_interval(16'd65535);
  endtask

  task automatic test_overlapping_bands();
    // Leader band covers parts of both bit bands and must win.
    set_bands(16'd1000, 16'd5000, 16'd0, 16'd3000, 16'd65535, 8'h00, 8'h00);
    send_interval(16'd2000);
    send_interval(16'd4000);
    send_interval(16'd6000);
    send_interval(16'd100);
    send_interval(16'd3000);
    send_interval(16'd1000);
    send_interval(16'd4999);
    send_interval(16'd65535);
  endtask

  task automatic test_config_extremes();
    set_bands(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'h00, 8'h00);
    send_interval(16'd0);
    send_interval(16'd1);
    send_interval(16'd32768);
    set_bands(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_interval(16'd0);
    send_interval(16'd65535);
    send_interval(16'd12345);
    set_bands(16'd0, 16'd65535, 16'd0, 16'd0, 16'd0, 8'hFF, 8'h00);
    send_interval(16'd1);
    send_interval(16'd65534);
    send_interval(16'd0);
    send_interval(16'd65535);
    set_bands(16'd60000, 16'd65535, 16'd0, 16'd30000, 16'd60001, 8'hFF, 8'hFF);
    drain();
    write_register(CfgUnusedIndex, 16'hFFFF);
    send_frame({8'h00, 8'hFF, 8'h00, 8'hFF}, -1, 1'b0);
  endtask

  task automatic test_random_frames(input int frames);
    int                   f;
    int                   kind;
    int                   cut_at;
    logic                 cut_lead;
    int                   zm, bs, om, lmin, lmax;
    logic [CodeWidth-1:0] user, key;
    logic [31:0]          word;
    for (f = 0; f < frames; f++) begin
      if (f % 4 == 0) begin
        zm = $urandom_range(2000);
        bs = zm + $urandom_range(3000, 2);
        om = bs + $urandom_range(4000, 2);
        lmin = om + $urandom_range(20000);
        lmax = lmin + $urandom_range(65535 - lmin, 2);
        set_bands(IntervalWidth'(lmin), IntervalWidth'(lmax), IntervalWidth'(zm),
                  IntervalWidth'(bs), IntervalWidth'(om),
                  CodeWidth'($urandom_range(255)), CodeWidth'($urandom_range(255)));
      end
      user = band_cfg.user_code;
      key = band_cfg.key_code;
      cut_at = -1;
      cut_lead = 1'b0;
      kind = $urandom_range(9);
      if (kind == 4) begin
        user = CodeWidth'($urandom);
        key = CodeWidth'($urandom);
      end
      word = {~key, key, ~user, user};
      case (kind)
        5: word = $urandom;
        6: word[$urandom_range(31)] ^= 1'b1;
        7: cut_at = $urandom_range(31);
        8: begin
          cut_at = $urandom_range(31);
          cut_lead = 1'b1;
        end
        default: ;
      endcase
      if (kind == 9)
        repeat ($urandom_range(8, 1)) send_interval(IntervalWidth'($urandom_range(65535)));
      else
        send_frame(word, cut_at, cut_lead);
    end
  endtask

  task automatic test_leader_wrap();
    int n;
    for (n = 0; n < 280; n++) begin
      if ($urandom_range(9) == 0)
        send_interval(IntervalWidth'($urandom_range(65535)));
      else
        send_interval(pick_in(band_cfg.leader_min, band_cfg.leader_max));
    end
  endtask

  task automatic test_output_backpressure();
    drain();
    // The receiver holds off long enough for the block to fill and stall its input.
    fork
      begin
        @(posedge clk);
        hold_on = 1'b1;
        repeat (200) @(posedge clk);
        hold_on = 1'b0;
      end
    join_none
    send_frame({~band_cfg.key_code, band_cfg.key_code, ~band_cfg.user_code, band_cfg.user_code},
               -1, 1'b0);
    repeat (20) send_interval(IntervalWidth'($urandom_range(65535)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_interval = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    band_cfg.leader_min = LeaderMinReset;
    band_cfg.leader_max = LeaderMaxReset;
    band_cfg.zero_min = ZeroMinReset;
    band_cfg.bit_split = BitSplitReset;
    band_cfg.one_max = OneMaxReset;
    band_cfg.user_code = UserCodeReset;
    band_cfg.key_code = KeyCodeReset;
    armed = 1'b0;
    bit_count = '0;
    frame_bytes = '{default: '0};
    frame_ok_hold = 1'b0;
    key_hold = '0;
    leader_count = '0;
    send_idle_pct = 35;
    recv_idle_pct = 88;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_band_edges();
    test_overlapping_bands();
    test_config_extremes();
    test_random_frames(8);

    drain();
    send_idle_pct = 88;
    recv_idle_pct = 35;
    test_leader_wrap();
    test_random_frames(8);

    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(8);
    test_output_backpressure();

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
